/* rtl/gdbd_pkg.sv */
// shared types, constants and calendar helpers for the gregorian date difference block
// no dependencies; used by the control, multiplier and top-level files

package gdbd_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned COUNT_W  = 22;
  localparam int unsigned STATUS_W = 2;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 15;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // day number width, wide enough for out-of-range years too
  localparam int unsigned DN_W = 24;
  // quotient by 100 of any year or shifted year (below 21184) stays below 256
  localparam int unsigned Q_W  = 8;

  localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_MAX  = MONTH_W'(12);
  localparam logic [MUL_A_W-1:0] YEAR_BIAS  = MUL_A_W'(4800);
  localparam logic [MUL_B_W-1:0] DAYS_YEAR  = MUL_B_W'(365);
  localparam logic [DN_W-1:0]    JDN_OFFSET = DN_W'(32045);

  // x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT for every x below 2^15
  localparam logic [MUL_B_W-1:0] DIV100_MUL   = MUL_B_W'(41944);
  localparam int unsigned        DIV100_SHIFT = 22;

  localparam logic [STATUS_W-1:0] ST_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_BAD_DATE = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_REVERSED = STATUS_W'(2);

  typedef enum logic [1:0] {
    MSEL_Y_DIV   = 2'd0,
    MSEL_YY_DIV  = 2'd1,
    MSEL_YY_DAYS = 2'd2
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     date_sel;  // 0 start date, 1 end date
    logic     cap_qy;
    logic     cap_qyy;
    logic     cap_dn;
    logic     load_out;
  } gdbd_ctrl_t;

  // days before the shifted month (march-based), (153*mm+2)/5
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] mm);
    logic [8:0] r;
    case (mm)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    r = DAY_W'(30);
      4'd2:    r = leap ? DAY_W'(29) : DAY_W'(28);
      default: r = DAY_W'(0);
    endcase
    return r;
  endfunction

endpackage

/* rtl/gdbd_mul.sv */
// shared multiplier with registered product
// depends on gdbd_pkg for operand widths

module gdbd_mul (
  input  logic                           clk,
  input  logic [gdbd_pkg::MUL_A_W-1:0]   a,
  input  logic [gdbd_pkg::MUL_B_W-1:0]   b,
  output logic [gdbd_pkg::MUL_P_W-1:0]   p_r
);

  logic [gdbd_pkg::MUL_P_W-1:0] p_nxt;

  assign p_nxt = gdbd_pkg::MUL_P_W'(a) * gdbd_pkg::MUL_P_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

/* rtl/gdbd_ctrl.sv */
// sequencer that steps both dates through the shared multiplier
// depends on gdbd_pkg for the control struct and operand selects

module gdbd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 out_free,
  output logic                 ready,
  output gdbd_pkg::gdbd_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MY,
    S_MYY,
    S_M365,
    S_ACC,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   date_r, date_nxt;

  always_comb begin
    state_nxt = state_r;
    date_nxt  = date_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_MY;
          date_nxt  = 1'b0;
        end
      end
      S_MY:   state_nxt = S_MYY;
      S_MYY:  state_nxt = S_M365;
      S_M365: state_nxt = S_ACC;
      S_ACC: begin
        if (date_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MY;
          date_nxt  = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      date_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      date_r  <= date_nxt;
    end
  end

  always_comb begin
    ctrl.date_sel = date_r;
    ctrl.cap_qy   = (state_r == S_MYY);
    ctrl.cap_qyy  = (state_r == S_M365);
    ctrl.cap_dn   = (state_r == S_ACC);
    ctrl.load_out = (state_r == S_FIN) && out_free;
    case (state_r)
      S_MYY:   ctrl.mul_sel = gdbd_pkg::MSEL_YY_DIV;
      S_M365:  ctrl.mul_sel = gdbd_pkg::MSEL_YY_DAYS;
      default: ctrl.mul_sel = gdbd_pkg::MSEL_Y_DIV;
    endcase
  end

  assign ready = (state_r == S_IDLE);

endmodule

/* rtl/gregorian_days_between_dates.sv */
// one date pair at a time: a new beat is taken only after the last result is loaded;
//   each date takes three passes through the single shared multiplier
//   (year/100, shifted year/100, shifted year * 365) plus one sum
// a new beat is taken while the previous result still waits on the output register
// reset: synchronous active-low rst_n clears the sequencer and the output valid flag
// depends on gdbd_pkg, gdbd_mul and gdbd_ctrl

module gregorian_days_between_dates (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata from bit 0: start_year[14], start_month[4], start_day[5],
  //   end_year[14], end_month[4], end_day[5], two zero bits
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // out_tdata from bit 0: day_count[22], status[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata
);

  localparam int unsigned YW = gdbd_pkg::YEAR_W;
  localparam int unsigned MW = gdbd_pkg::MONTH_W;
  localparam int unsigned DW = gdbd_pkg::DAY_W;
  localparam int unsigned AW = gdbd_pkg::MUL_A_W;
  localparam int unsigned BW = gdbd_pkg::MUL_B_W;
  localparam int unsigned PW = gdbd_pkg::MUL_P_W;
  localparam int unsigned NW = gdbd_pkg::DN_W;
  localparam int unsigned QW = gdbd_pkg::Q_W;
  localparam int unsigned CW = gdbd_pkg::COUNT_W;
  localparam int unsigned SW = gdbd_pkg::STATUS_W;
  localparam int unsigned QS = gdbd_pkg::DIV100_SHIFT;

  gdbd_pkg::gdbd_ctrl_t ctrl;
  logic                 in_fire;
  logic                 out_free;

  // captured input dates
  logic [YW-1:0] sy_r, ey_r;
  logic [MW-1:0] sm_r, em_r;
  logic [DW-1:0] sd_r, ed_r;

  // working registers
  logic [QW-1:0] qy_r, qyy_r;       // year/100 and shifted year/100
  logic [NW-1:0] dn_s_r, dn_e_r;    // day numbers of start and end
  logic          ok_r, ok_nxt;      // both dates valid so far

  // output register
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic [SW-1:0] out_status_r, out_status_nxt;

  // selected date and derived terms
  logic [YW-1:0] y;
  logic [MW-1:0] m;
  logic [DW-1:0] d;
  logic          early;             // january or february, counts with previous year
  logic [AW-1:0] yy;
  logic [MW-1:0] mm;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] p_r;
  logic [NW-1:0] dn_sum;
  logic [YW-1:0] y_hundreds;
  logic          leap;
  logic          date_ok;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  gdbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ready    (in_tready),
    .ctrl     (ctrl)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sy_r <= in_tdata[13:0];
      sm_r <= in_tdata[17:14];
      sd_r <= in_tdata[22:18];
      ey_r <= in_tdata[36:23];
      em_r <= in_tdata[40:37];
      ed_r <= in_tdata[45:41];
    end
  end

  // date under work
  assign y = ctrl.date_sel ? ey_r : sy_r;
  assign m = ctrl.date_sel ? em_r : sm_r;
  assign d = ctrl.date_sel ? ed_r : sd_r;

  // march-based year: jan and feb belong to the previous year
  assign early = (m <= MW'(2));
  assign yy    = AW'(y) + gdbd_pkg::YEAR_BIAS - AW'(early);
  assign mm    = early ? (m + MW'(9)) : (m - MW'(3));

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl.mul_sel)
      gdbd_pkg::MSEL_Y_DIV: begin
        mul_a = AW'(y);
        mul_b = gdbd_pkg::DIV100_MUL;
      end
      gdbd_pkg::MSEL_YY_DIV: begin
        mul_a = yy;
        mul_b = gdbd_pkg::DIV100_MUL;
      end
      gdbd_pkg::MSEL_YY_DAYS: begin
        mul_a = yy;
        mul_b = gdbd_pkg::DAYS_YEAR;
      end
      default: begin
        mul_a = yy;
        mul_b = gdbd_pkg::DAYS_YEAR;
      end
    endcase
  end

  gdbd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  // quotients by 100 come from the top bits of the reciprocal product
  always_ff @(posedge clk) begin
    if (ctrl.cap_qy) begin
      qy_r <= p_r[QS+QW-1:QS];
    end
    if (ctrl.cap_qyy) begin
      qyy_r <= p_r[QS+QW-1:QS];
    end
  end

  // day number: 365*yy + yy/4 - yy/100 + yy/400 + month offset + day - offset
  assign dn_sum = NW'(p_r[NW-2:0]) + NW'(d) + NW'(gdbd_pkg::month_offset(mm))
                + NW'(yy[AW-1:2]) - NW'(qyy_r) + NW'(qyy_r[QW-1:2])
                - gdbd_pkg::JDN_OFFSET;

  // leap: divisible by 4, and either not by 100 or by 400 (y == 100*q and q%4 == 0)
  assign y_hundreds = (YW'(qy_r) << 6) + (YW'(qy_r) << 5) + (YW'(qy_r) << 2);
  assign leap       = (y[1:0] == 2'b00) && ((y != y_hundreds) || (qy_r[1:0] == 2'b00));

  assign date_ok = (y >= YW'(1)) && (y <= gdbd_pkg::YEAR_MAX)
                && (m >= MW'(1)) && (m <= gdbd_pkg::MONTH_MAX)
                && (d >= DW'(1)) && (d <= gdbd_pkg::month_len(m, leap));

  assign ok_nxt = ctrl.date_sel ? (ok_r && date_ok) : date_ok;

  always_ff @(posedge clk) begin
    if (ctrl.cap_dn) begin
      ok_r <= ok_nxt;
      if (ctrl.date_sel) begin
        dn_e_r <= dn_sum;
      end else begin
        dn_s_r <= dn_sum;
      end
    end
  end

  // final compare and difference
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (ctrl.load_out) begin
      out_tvalid_nxt = 1'b1;
      if (!ok_r) begin
        out_status_nxt = gdbd_pkg::ST_BAD_DATE;
        out_count_nxt  = '0;
      end else if (dn_e_r < dn_s_r) begin
        out_status_nxt = gdbd_pkg::ST_REVERSED;
        out_count_nxt  = '0;
      end else begin
        out_status_nxt = gdbd_pkg::ST_OK;
        out_count_nxt  = CW'(dn_e_r - dn_s_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_status_r, out_count_r};

endmodule

/* rtl/gdbd_checker.sv */
// port-level checks on the date difference block, bound to the top level
// depends only on the ports of gregorian_days_between_dates

module gdbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a held result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // reset leaves no result on the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // the sequencer is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before the item was worked");

  // status code three is never produced
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:22] != 2'd3))
    else $error("undefined status code");

  // an error status carries a zero day count
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[23:22] != 2'd0) |-> (out_tdata[21:0] == 22'd0))
    else $error("non-zero day count with error status");

endmodule

bind gregorian_days_between_dates gdbd_checker u_gdbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* bench/tb.sv */
// self-checking bench for gregorian_days_between_dates: directed and random date pairs
// are driven over the input stream and each day count and status is checked on the way out
// depends on gdbd_pkg and the gregorian_days_between_dates rtl

module tb;

  localparam int unsigned RANDOM_PAIRS = 80;
  localparam int unsigned CALM_TAIL    = 20;    // last beats sent with no idling on either side
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int unsigned SETTLE       = 30;    // cycles allowed after the last result

  // field order matches in_tdata from the msb down, so {2'b0, pair} is the beat
  typedef struct packed {
    logic [gdbd_pkg::DAY_W-1:0]   end_day;
    logic [gdbd_pkg::MONTH_W-1:0] end_month;
    logic [gdbd_pkg::YEAR_W-1:0]  end_year;
    logic [gdbd_pkg::DAY_W-1:0]   start_day;
    logic [gdbd_pkg::MONTH_W-1:0] start_month;
    logic [gdbd_pkg::YEAR_W-1:0]  start_year;
  } date_pair_t;

  typedef struct {
    date_pair_t pair;
    bit         drain_first;  // hold this beat back until every result is home
  } queued_pair_t;

  typedef struct {
    logic [gdbd_pkg::COUNT_W-1:0]  day_count;
    logic [gdbd_pkg::STATUS_W-1:0] status;
  } span_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  queued_pair_t pending_pairs[$];
  span_t        expected_spans[$];
  date_pair_t   pair_on_bus;
  bit           calm = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  recv_stall = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  errors = 0;
  int unsigned  pairs_sent = 0;
  int unsigned  n_ok = 0, n_bad = 0, n_rev = 0;

  gregorian_days_between_dates DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // calendar arithmetic for the expected results
  // ---------------------------------------------------------------------------

  // 4/100/400 rule
  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
    return (y >= 1) && (y <= 9999) && (m >= 1) && (m <= 12) &&
           (d >= 1) && (d <= days_in_month(m, y));
  endfunction

  // running day number with the year shifted to start in march, so the leap day
  // falls at the end of the shifted year
  function automatic int unsigned serial_day(int unsigned y, int unsigned m, int unsigned d);
    int unsigned jan_feb, sy, sm;
    jan_feb = (m <= 2) ? 1 : 0;
    sy = y + 4800 - jan_feb;
    sm = m + 12 * jan_feb - 3;
    return d + (153 * sm + 2) / 5 + 365 * sy + sy / 4 - sy / 100 + sy / 400 - 32045;
  endfunction

  function automatic span_t calc_span(date_pair_t p);
    span_t       r;
    int unsigned from_day, to_day;
    r.day_count = '0;
    if (!date_valid(p.start_year, p.start_month, p.start_day) ||
        !date_valid(p.end_year, p.end_month, p.end_day)) begin
      // a bad field wins over the ordering check
      r.status = gdbd_pkg::ST_BAD_DATE;
    end else begin
      from_day = serial_day(p.start_year, p.start_month, p.start_day);
      to_day   = serial_day(p.end_year, p.end_month, p.end_day);
      if (to_day < from_day) begin
        r.status = gdbd_pkg::ST_REVERSED;
      end else begin
        r.status    = gdbd_pkg::ST_OK;
        r.day_count = gdbd_pkg::COUNT_W'(to_day - from_day);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_pair(int unsigned sy, int unsigned sm, int unsigned sd,
                            int unsigned ey, int unsigned em, int unsigned ed,
                            bit drain = 1'b0);
    queued_pair_t q;
    q.pair.start_year  = gdbd_pkg::YEAR_W'(sy);
    q.pair.start_month = gdbd_pkg::MONTH_W'(sm);
    q.pair.start_day   = gdbd_pkg::DAY_W'(sd);
    q.pair.end_year    = gdbd_pkg::YEAR_W'(ey);
    q.pair.end_month   = gdbd_pkg::MONTH_W'(em);
    q.pair.end_day     = gdbd_pkg::DAY_W'(ed);
    q.drain_first      = drain;
    pending_pairs.push_back(q);
  endtask

  // a pair of well-formed dates, mostly anywhere in range, sometimes with the end year near the start year
  function automatic date_pair_t legal_pair(bit close_years);
    date_pair_t p;
    int unsigned y0, y1, m0, m1;
    y0 = $urandom_range(1, 9999);
    y1 = close_years ? ((y0 < 9997) ? y0 + $urandom_range(0, 2) : y0)
                     : $urandom_range(1, 9999);
    m0 = $urandom_range(1, 12);
    m1 = $urandom_range(1, 12);
    p.start_year  = gdbd_pkg::YEAR_W'(y0);
    p.start_month = gdbd_pkg::MONTH_W'(m0);
    p.start_day   = gdbd_pkg::DAY_W'($urandom_range(1, days_in_month(m0, y0)));
    p.end_year    = gdbd_pkg::YEAR_W'(y1);
    p.end_month   = gdbd_pkg::MONTH_W'(m1);
    p.end_day     = gdbd_pkg::DAY_W'($urandom_range(1, days_in_month(m1, y1)));
    return p;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: takes pairs from the pending queue, idles in random bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      calm <= (pending_pairs.size() <= CALM_TAIL);
      if (in_tvalid && in_tready) begin
        expected_spans.push_back(calc_span(pair_on_bus));
        pairs_sent++;
      end
      // bus is free for a new beat when nothing is held or the held one just went
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_pairs.size() == 0 ||
                     (pending_pairs[0].drain_first && expected_spans.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          // idle burst: this cycle plus send_gap more
          send_gap  <= $urandom_range(0, 14);
          in_tvalid <= 1'b0;
        end else begin
          pair_on_bus <= pending_pairs[0].pair;
          in_tdata    <= {2'b00, pending_pairs[0].pair};
          in_tvalid   <= 1'b1;
          pending_pairs.pop_front();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, checks each result beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    span_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_spans.size() == 0) begin
          flag_mismatch("results outstanding", 0, 1);
        end else begin
          want = expected_spans.pop_front();
          if (out_tdata[gdbd_pkg::COUNT_W-1:0] !== want.day_count)
            flag_mismatch("day_count", out_tdata[gdbd_pkg::COUNT_W-1:0], want.day_count);
          if (out_tdata[gdbd_pkg::COUNT_W +: gdbd_pkg::STATUS_W] !== want.status)
            flag_mismatch("status", out_tdata[gdbd_pkg::COUNT_W +: gdbd_pkg::STATUS_W],
                          want.status);
          case (want.status)
            gdbd_pkg::ST_OK:       n_ok++;
            gdbd_pkg::ST_BAD_DATE: n_bad++;
            default:               n_rev++;
          endcase
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        recv_stall <= $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no beat on either side ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("timeout: %0d results still outstanding", expected_spans.size());
      $display("gregorian_days_between_dates verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    date_pair_t p;
    int unsigned pick;

    // directed: range ends, leap rules, each kind of bad field, ordering
    queue_pair(1, 1, 1, 1, 1, 1);                // equal dates
    queue_pair(1, 1, 1, 9999, 12, 31);           // widest span
    queue_pair(9999, 12, 31, 1, 1, 1);           // widest span reversed
    queue_pair(2000, 2, 29, 2000, 3, 1);         // leap by the 400 rule
    queue_pair(1900, 2, 29, 1900, 3, 1);         // century year not leap
    queue_pair(2004, 2, 29, 2005, 2, 28);
    queue_pair(2023, 2, 29, 2023, 3, 1);         // feb 29 in a common year
    queue_pair(2024, 4, 30, 2024, 4, 31);        // day past a 30-day month
    queue_pair(0, 1, 1, 1, 1, 1);                // year zero
    queue_pair(1, 1, 1, 10000, 1, 1);            // year just past the top
    queue_pair(16383, 15, 31, 16383, 15, 31);    // every field all ones
    queue_pair(0, 0, 0, 0, 0, 0);                // every field zero
    queue_pair(2020, 0, 10, 2021, 1, 1);         // month zero
    queue_pair(2020, 5, 10, 2021, 13, 1);        // month thirteen
    queue_pair(2020, 5, 10, 2021, 1, 0);         // day zero
    queue_pair(2023, 12, 31, 2024, 1, 1);
    queue_pair(2000, 1, 1, 1999, 12, 31);        // reversed by one day
    queue_pair(2024, 2, 28, 2024, 2, 29);
    queue_pair(2100, 2, 28, 2100, 3, 1);
    queue_pair(1582, 10, 4, 1582, 10, 15);       // calendar switch, proleptic
    queue_pair(1, 12, 31, 2, 1, 1);
    queue_pair(9999, 12, 31, 0, 1, 1);           // bad field wins over ordering
    queue_pair(2000, 1, 31, 2000, 6, 30);

    // random: mostly legal pairs, some near misses and some raw noise
    for (int unsigned i = 0; i < RANDOM_PAIRS; i++) begin
      pick = $urandom_range(0, 99);
      p = legal_pair($urandom_range(0, 3) == 0);
      if (pick < 10) begin
        p.end_year  = p.start_year;
        p.end_month = p.start_month;
        p.end_day   = p.start_day;
      end else if (pick < 20) begin
        // one field out of range (a start day in a 31-day month may stay legal)
        case ($urandom_range(0, 3))
          0: p.start_year = $urandom_range(0, 1) ? gdbd_pkg::YEAR_W'(0)
                                                 : gdbd_pkg::YEAR_W'($urandom_range(10000, 16383));
          1: p.end_month  = $urandom_range(0, 1) ? gdbd_pkg::MONTH_W'(0)
                                                 : gdbd_pkg::MONTH_W'($urandom_range(13, 15));
          2: p.start_day  = gdbd_pkg::DAY_W'($urandom_range(
                              days_in_month(p.start_month, p.start_year) + 1, 31));
          default: p.end_day = gdbd_pkg::DAY_W'(0);
        endcase
      end else if (pick < 35) begin
        p = date_pair_t'(46'({$urandom(), $urandom()}));
      end
      pending_pairs.push_back('{pair: p, drain_first: (i == 40)});
    end
    // the first random beat also waits for the directed results to drain
    pending_pairs[23].drain_first = 1'b1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d date pairs sent: %0d spans counted, %0d rejected for a bad field, %0d reversed",
             pairs_sent, n_ok, n_bad, n_rev);
    $display("stimulus covered range ends, leap rules, bad fields and random back-pressure");
    if (errors == 0)
      $display("gregorian_days_between_dates verification clean");
    else
      $display("gregorian_days_between_dates verification failed");
    $finish;
  end

endmodule
